// ----- hw/rtl/lpf_pkg.sv -----
// Shared widths, command and status types for the lookahead point finder.
// Used by lpf_ctrl, lpf_datapath and lookahead_point_finder_core; no dependencies.
package lpf_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W = 24;
	localparam int LA_W    = 23;
	localparam int OIDX_W  = 8;

	// Arithmetic widths: |difference| needs 25 bits, its square fits 49 bits,
	// the sum of two squares fits 50 bits, the lookahead square fits 46 bits.
	localparam int ABS_W  = COORD_W + 1;
	localparam int SQ_W   = 49;
	localparam int DIST_W = 50;
	localparam int BEST_W = 51;
	localparam int LA2_W  = 2 * LA_W;

	// Configuration register indexes.
	localparam logic REG_LOOKAHEAD = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // capture one input beat
		logic square;     // form the two squares
		logic store;      // sum, write the point, track the closest
		logic scan_init;  // start the forward scan at the closest point
		logic scan_read;  // read the entry under the scan pointer
		logic scan_check; // test the entry read, finish or advance
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;       // the captured point closes the path
		logic scan_end;   // the entry read ends the scan
	} stat_t;

endpackage

// ----- hw/rtl/lookahead_point_finder_core.sv -----
// Top level of the lookahead point finder: configuration register, controller
// and datapath. Depends on lpf_pkg, lpf_ctrl and lpf_datapath.
//
//  channel   | handshake            | beat contents
//  ----------+----------------------+--------------------------------------------------
//  input     | start & !busy        | robot_x, robot_y, point_x, point_y, last_point
//  result    | done (one cycle)     | chosen_index, chosen_x, chosen_y, beyond_found,
//            |                      | path_overflow
//  config    | psel&penable&pwrite  | lookahead_distance at byte address 0
//
// Each point is squared in the two multipliers, then summed, stored and checked
// against the closest point; the next point is taken in the store cycle. After the
// last point the scan runs from the closest point forward, each entry a memory read
// and a compare. Reset is asynchronous and needs no memory clearing pass. The result
// strobe cannot be held off.
module lookahead_point_finder_core #(
	parameter int MAX_POINTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [lpf_pkg::COORD_W-1:0]  robot_x,
	input  logic signed [lpf_pkg::COORD_W-1:0]  robot_y,
	input  logic signed [lpf_pkg::COORD_W-1:0]  point_x,
	input  logic signed [lpf_pkg::COORD_W-1:0]  point_y,
	input  logic                                last_point,
	output logic                                done,
	output logic        [lpf_pkg::OIDX_W-1:0]   chosen_index,
	output logic signed [lpf_pkg::COORD_W-1:0]  chosen_x,
	output logic signed [lpf_pkg::COORD_W-1:0]  chosen_y,
	output logic                                beyond_found,
	output logic                                path_overflow,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [2:0]                   paddr,
	input  logic        [31:0]                  pwdata,
	output logic        [31:0]                  prdata,
	output logic                                pready
);

	lpf_pkg::cmd_t         cmd;
	lpf_pkg::stat_t        stat;
	logic [lpf_pkg::LA_W-1:0] la_q;
	logic                  sel_la;

	// Register decode: the word index is the upper address bit.
	assign sel_la = (paddr[2] == lpf_pkg::REG_LOOKAHEAD);
	assign pready = 1'b1;
	assign prdata = sel_la ? {{(32 - lpf_pkg::LA_W){1'b0}}, la_q} : 32'd0;

	// Lookahead distance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) la_q <= lpf_pkg::LA_W'(256);
		else if (psel && penable && pwrite && pready && sel_la) la_q <= pwdata[lpf_pkg::LA_W-1:0];
	end

	lpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lpf_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.lookahead     (la_q),
		.robot_x       (robot_x),
		.robot_y       (robot_y),
		.point_x       (point_x),
		.point_y       (point_y),
		.last_point    (last_point),
		.done          (done),
		.chosen_index  (chosen_index),
		.chosen_x      (chosen_x),
		.chosen_y      (chosen_y),
		.beyond_found  (beyond_found),
		.path_overflow (path_overflow)
	);

endmodule

// ----- hw/rtl/lpf_ctrl.sv -----
// Controller state machine of the lookahead point finder.
// Depends on lpf_pkg for the command and status types.
module lpf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lpf_pkg::stat_t stat,
	output lpf_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_STORE = 3'd2;
	localparam logic [2:0] ST_INIT  = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       open;

	// A new beat is taken while idle, or while storing a point that is not the last.
	assign open = (state_q == ST_IDLE) || ((state_q == ST_STORE) && !stat.last);
	assign busy = !open;

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.accept     = open && start;
		cmd.square     = (state_q == ST_MUL);
		cmd.store      = (state_q == ST_STORE);
		cmd.scan_init  = (state_q == ST_INIT);
		cmd.scan_read  = (state_q == ST_READ);
		cmd.scan_check = (state_q == ST_CHECK);
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_STORE;
			end
			ST_STORE: begin
				if (stat.last) state_d = ST_INIT;
				else if (start) state_d = ST_MUL;
				else state_d = ST_IDLE;
			end
			ST_INIT: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.scan_end) state_d = ST_IDLE;
				else state_d = ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// A beat is never taken during the scan.
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_READ || state_q == ST_CHECK) |-> !cmd.accept)
		else $error("beat accepted during scan");

	// Every accepted beat is squared in the next cycle.
	a_accept_then_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_MUL)
		else $error("accepted beat not squared");

	// A read is always followed by its check.
	a_read_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_CHECK)
		else $error("scan read without check");

endmodule

// ----- hw/rtl/lpf_datapath.sv -----
// Datapath of the lookahead point finder: distance arithmetic, point memory,
// closest-point tracking and forward scan. Depends on lpf_pkg.
module lpf_datapath #(
	parameter int MAX_POINTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpf_pkg::cmd_t                       cmd,
	output lpf_pkg::stat_t                      stat,
	input  logic        [lpf_pkg::LA_W-1:0]     lookahead,
	input  logic signed [lpf_pkg::COORD_W-1:0]  robot_x,
	input  logic signed [lpf_pkg::COORD_W-1:0]  robot_y,
	input  logic signed [lpf_pkg::COORD_W-1:0]  point_x,
	input  logic signed [lpf_pkg::COORD_W-1:0]  point_y,
	input  logic                                last_point,
	output logic                                done,
	output logic        [lpf_pkg::OIDX_W-1:0]   chosen_index,
	output logic signed [lpf_pkg::COORD_W-1:0]  chosen_x,
	output logic signed [lpf_pkg::COORD_W-1:0]  chosen_y,
	output logic                                beyond_found,
	output logic                                path_overflow
);

	localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int ENTRY_W = 2 * lpf_pkg::COORD_W + lpf_pkg::DIST_W;

	// Path state.
	logic                          path_open_q;
	logic [CNT_W-1:0]              count_q;
	logic [lpf_pkg::BEST_W-1:0]    best_q;
	logic [IDX_W-1:0]              best_idx_q;
	logic                          ovf_q;
	logic [IDX_W-1:0]              scan_q;
	logic                          done_q;

	// Payload registers.
	logic [lpf_pkg::COORD_W-1:0]   hold_x_q, hold_y_q;
	logic [lpf_pkg::COORD_W-1:0]   px_q, py_q;
	logic                          last_q;
	logic [lpf_pkg::ABS_W-1:0]     adx_q, ady_q;
	logic [lpf_pkg::SQ_W-1:0]      sqx_q, sqy_q;
	logic [lpf_pkg::LA2_W-1:0]     la2_q;
	logic [ENTRY_W-1:0]            rd_q;
	logic [ENTRY_W-1:0]            mem [MAX_POINTS];
	logic [lpf_pkg::OIDX_W-1:0]    res_idx_q;
	logic [lpf_pkg::COORD_W-1:0]   res_x_q, res_y_q;
	logic                          res_found_q, res_ovf_q;

	// Combinational helpers.
	logic [lpf_pkg::COORD_W-1:0]   rx, ry;
	logic [lpf_pkg::ABS_W-1:0]     dx, dy;
	logic [lpf_pkg::DIST_W-1:0]    sum_sq;
	logic                          room;
	logic [lpf_pkg::DIST_W-1:0]    rd_dist;
	logic                          hit;
	logic                          final_entry;

	// The robot position is sampled with the first point of a path.
	assign rx = path_open_q ? hold_x_q : robot_x;
	assign ry = path_open_q ? hold_y_q : robot_y;
	assign dx = {point_x[lpf_pkg::COORD_W-1], point_x} - {rx[lpf_pkg::COORD_W-1], rx};
	assign dy = {point_y[lpf_pkg::COORD_W-1], point_y} - {ry[lpf_pkg::COORD_W-1], ry};

	// Sum of squares and the capacity test for the store cycle.
	assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign room   = count_q < CNT_W'(MAX_POINTS);

	// Scan test on the entry read from memory.
	assign rd_dist     = rd_q[lpf_pkg::DIST_W-1:0];
	assign hit         = rd_dist >= lpf_pkg::DIST_W'(la2_q);
	assign final_entry = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;

	assign stat.last     = last_q;
	assign stat.scan_end = hit || final_entry;

	// Input capture, absolute differences and squares.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q   <= point_x;
			py_q   <= point_y;
			last_q <= last_point;
			adx_q  <= dx[lpf_pkg::ABS_W-1] ? (~dx + lpf_pkg::ABS_W'(1)) : dx;
			ady_q  <= dy[lpf_pkg::ABS_W-1] ? (~dy + lpf_pkg::ABS_W'(1)) : dy;
		end
		if (cmd.square) begin
			sqx_q <= lpf_pkg::SQ_W'(adx_q) * lpf_pkg::SQ_W'(adx_q);
			sqy_q <= lpf_pkg::SQ_W'(ady_q) * lpf_pkg::SQ_W'(ady_q);
		end
		la2_q <= lpf_pkg::LA2_W'(lookahead) * lpf_pkg::LA2_W'(lookahead);
	end

	// Held robot position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_x_q <= '0;
			hold_y_q <= '0;
		end else if (cmd.accept && !path_open_q) begin
			hold_x_q <= robot_x;
			hold_y_q <= robot_y;
		end
	end

	// Point memory: one write port in the store cycle, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store && room) begin
			mem[count_q[IDX_W-1:0]] <= {px_q, py_q, sum_sq};
		end
		if (cmd.scan_read) begin
			rd_q <= mem[scan_q];
		end
	end

	// Path tracking, closest point and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_open_q <= 1'b0;
			count_q     <= '0;
			best_q      <= '1;
			best_idx_q  <= '0;
			ovf_q       <= 1'b0;
			scan_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.accept) path_open_q <= 1'b1;
			if (cmd.store) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
					if ({1'b0, sum_sq} < best_q) begin
						best_q     <= {1'b0, sum_sq};
						best_idx_q <= count_q[IDX_W-1:0];
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.scan_init) scan_q <= best_idx_q;
			if (cmd.scan_check) begin
				if (stat.scan_end) begin
					done_q      <= 1'b1;
					path_open_q <= 1'b0;
					count_q     <= '0;
					best_q      <= '1;
					best_idx_q  <= '0;
					ovf_q       <= 1'b0;
				end else begin
					scan_q <= scan_q + IDX_W'(1);
				end
			end
		end
	end

	// Result registers; the read entry is the chosen point in both end cases.
	always_ff @(posedge clk) begin
		if (cmd.scan_check && stat.scan_end) begin
			res_idx_q   <= lpf_pkg::OIDX_W'(scan_q);
			res_x_q     <= rd_q[ENTRY_W-1 -: lpf_pkg::COORD_W];
			res_y_q     <= rd_q[lpf_pkg::DIST_W +: lpf_pkg::COORD_W];
			res_found_q <= hit;
			res_ovf_q   <= ovf_q;
		end
	end

	assign done          = done_q;
	assign chosen_index  = res_idx_q;
	assign chosen_x      = res_x_q;
	assign chosen_y      = res_y_q;
	assign beyond_found  = res_found_q;
	assign path_overflow = res_ovf_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");

	// Points are dropped only once the memory is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_POINTS))
		else $error("overflow flagged with room left");

	// The closest point is always one that was stored.
	a_best_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> CNT_W'(best_idx_q) < count_q)
		else $error("closest index outside stored points");

	// A result leaves the path state cleared.
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (count_q == '0) && !ovf_q && !path_open_q)
		else $error("path state not cleared after result");

endmodule
